// File: src/r2m_pkg.sv
`default_nettype none
package r2m_pkg;

  // Field widths fixed by the interface.
  localparam int WID_W  = 13;  // image_width
  localparam int HGT_W  = 16;  // image_height, row counter
  localparam int POS_W  = 14;  // bytes_per_line, byte position, packed count
  localparam int CS_W   = 6;   // color_space
  localparam int PIX3_W = 13;  // pixel index in rgb mode (position / 3)
  localparam int CFG_W  = 16;  // configuration write data
  localparam int CIDX_W = 3;   // configuration register index
  localparam int CNT_W  = 7;   // results of one beat, up to 64
  localparam int HEX_W  = 7;   // ASCII character

  localparam int R2M_MAX_WIDTH = 4096;
  localparam int R2M_MAX_PAD   = 64;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DEPTH_MODE     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BYTES_PER_LINE = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_COLOR_SPACE    = 3'd4;

  // Colorspace codes in which white is the high value.
  localparam logic [CS_W-1:0] CS_W_CODE    = 6'd0;
  localparam logic [CS_W-1:0] CS_SW_CODE   = 6'd18;
  localparam logic [CS_W-1:0] CS_SRGB_CODE = 6'd19;

  // Luma in units of 1/1000.
  localparam int LUMA_W = 18;
  localparam logic [LUMA_W-1:0] LUMA_RED   = 18'd299;
  localparam logic [LUMA_W-1:0] LUMA_GREEN = 18'd587;
  localparam logic [LUMA_W-1:0] LUMA_BLUE  = 18'd114;
  localparam logic [LUMA_W-1:0] LUMA_THR   = 18'd128000;

  localparam logic [7:0] PAD_WHITE = 8'hFF;

  typedef enum logic [1:0] {
    DEPTH_ONE_BIT = 2'd0,
    DEPTH_GRAY    = 2'd1,
    DEPTH_RGB     = 2'd2,
    DEPTH_NONE    = 2'd3
  } depth_mode_t;

  typedef struct packed {
    logic [WID_W-1:0] image_width;
    logic [HGT_W-1:0] image_height;
    depth_mode_t      depth_mode;
    logic [POS_W-1:0] bytes_per_line;
    logic [CS_W-1:0]  color_space;
  } cfg_t;

  // Results caused by one input beat: up to three distinct byte values
  // (data, first pad, remaining pads) and the flags of the final result.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic             fin_row;
    logic             fin_label;
    logic             trunc;
  } job_t;

  function automatic logic [HEX_W-1:0] hex_digit(input logic [3:0] n);
    logic [HEX_W-1:0] ext;
    ext = {3'b000, n};
    return (n < 4'd10) ? (7'h30 + ext) : (7'h37 + ext);
  endfunction

endpackage
`default_nettype wire

// File: src/raster_to_mono_hex_top.sv
// Raster to 1-bit packer with ASCII hex digits.
// Input channel: one raster byte per beat (in_valid / in_stall), rows of
// bytes_per_line bytes. Result channel: one packed byte per beat with its two
// uppercase hex characters and row, label and truncation flags.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (0 width, 1 height, 2 depth mode, 3 bytes per line, 4 colorspace); write it
// only while no beat is in flight.
// Latency: a packed byte appears on the result channel in the cycle after the
// input beat that completes it. Throughput is one input beat per cycle while
// each beat yields at most one result and the receiver does not stall.
// A beat that ends a short row also yields the row's padding: up to
// MAX_PAD_RESULTS results, one per cycle from the result register unless the
// receiver stalls, and in_stall stays high until the last of them is leaving.
// A receiver stall holds the current result; in_stall then rises as soon as
// the result register cannot take the next beat.
// Reset restores the register defaults and clears the row position, pixel
// accumulator and row counter; nothing is pending afterwards.
`default_nettype none
module raster_to_mono_hex_top
  import r2m_pkg::*;
#(
  parameter int MAX_WIDTH       = R2M_MAX_WIDTH,
  parameter int MAX_PAD_RESULTS = R2M_MAX_PAD
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_source_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_mono_byte,
  output logic [HEX_W-1:0]       out_hex_high,
  output logic [HEX_W-1:0]       out_hex_low,
  output logic                   out_last_of_row,
  output logic                   out_last_of_label,
  output logic                   out_pad_truncated
);

  cfg_t cfg_r;
  job_t job;
  logic can_load;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= 13'd1;
      cfg_r.image_height   <= 16'd1;
      cfg_r.depth_mode     <= DEPTH_ONE_BIT;
      cfg_r.bytes_per_line <= 14'd1;
      cfg_r.color_space    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_wdata[WID_W-1:0];
        CFG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_wdata[HGT_W-1:0];
        CFG_DEPTH_MODE:     cfg_r.depth_mode     <= depth_mode_t'(cfg_wdata[1:0]);
        CFG_BYTES_PER_LINE: cfg_r.bytes_per_line <= cfg_wdata[POS_W-1:0];
        CFG_COLOR_SPACE:    cfg_r.color_space    <= cfg_wdata[CS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !can_load;
  assign take     = in_valid && can_load;

  r2m_core #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_PAD_RESULTS (MAX_PAD_RESULTS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .take        (take),
    .source_byte (in_source_byte),
    .job         (job)
  );

  r2m_emit #(
    .MAX_PAD_RESULTS (MAX_PAD_RESULTS)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .job               (job),
    .take              (take),
    .can_load          (can_load),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mono_byte     (out_mono_byte),
    .out_hex_high      (out_hex_high),
    .out_hex_low       (out_hex_low),
    .out_last_of_row   (out_last_of_row),
    .out_last_of_label (out_last_of_label),
    .out_pad_truncated (out_pad_truncated)
  );

endmodule
`default_nettype wire

// File: src/r2m_core.sv
`default_nettype none
module r2m_core
  import r2m_pkg::*;
#(
  parameter int MAX_WIDTH       = R2M_MAX_WIDTH,
  parameter int MAX_PAD_RESULTS = R2M_MAX_PAD
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       take,
  input  wire logic [7:0] source_byte,
  output job_t            job
);

  localparam int WMAX = (1 << WID_W) - 1;
  localparam int WCAP = (MAX_WIDTH < WMAX) ? MAX_WIDTH : WMAX;
  localparam logic [WID_W-1:0] WCAP_V  = WID_W'(WCAP);
  localparam logic [CNT_W-1:0] PAD_LIM = CNT_W'(MAX_PAD_RESULTS);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  pc_r, pc_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic [7:0]        red_r, red_nxt;
  logic [7:0]        green_r, green_nxt;
  logic [1:0]        chan_r, chan_nxt;
  logic [PIX3_W-1:0] pix3_r, pix3_nxt;
  logic [HGT_W-1:0]  row_r, row_nxt;

  logic [WID_W-1:0]  w;
  logic [POS_W-1:0]  w_ext;
  logic [POS_W-1:0]  bpr;
  logic [POS_W-1:0]  bpl;
  logic [HGT_W-1:0]  hgt;
  logic              label_end;
  logic              row_end;
  logic              wh;
  logic [7:0]        pad_byte;
  logic [LUMA_W-1:0] luma;
  logic              gray_dark;
  logic              rgb_dark;

  logic              pix_en;
  logic [POS_W-1:0]  pix_idx;
  logic              pix_dark;
  logic              in_row;
  logic [7:0]        acc_set;
  logic              pix_emit;

  logic              has_data;
  logic [7:0]        data_byte;
  logic [7:0]        acc_after;
  logic [POS_W-1:0]  pc_after;
  logic [POS_W-1:0]  remaining;
  logic [CNT_W-1:0]  limit;
  logic              trunc;
  logic [CNT_W-1:0]  pad_n;
  logic [7:0]        pad_first;

  assign w     = (cfg.image_width > WCAP_V) ? WCAP_V : cfg.image_width;
  assign w_ext = POS_W'(w);
  assign bpr   = (w_ext + 14'd7) >> 3;
  assign bpl   = (cfg.bytes_per_line == '0) ? 14'd1 : cfg.bytes_per_line;
  assign hgt   = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;

  assign label_end = ({1'b0, row_r} + 17'd1) >= {1'b0, hgt};
  assign row_end   = ({1'b0, pos_r} + 15'd1) >= {1'b0, bpl};

  assign wh = (cfg.color_space == CS_W_CODE) || (cfg.color_space == CS_SW_CODE) ||
              (cfg.color_space == CS_SRGB_CODE);
  assign pad_byte = (cfg.depth_mode == DEPTH_ONE_BIT && wh) ? PAD_WHITE : 8'h00;

  // Red and green are held as they arrive; the whole luma is formed in the
  // blue beat so a mode change mid-row still uses the latest held channels.
  assign luma      = LUMA_RED * LUMA_W'(red_r) + LUMA_GREEN * LUMA_W'(green_r) +
                     LUMA_BLUE * LUMA_W'(source_byte);
  assign gray_dark = source_byte[7] ^ wh;
  assign rgb_dark  = (luma >= LUMA_THR) ^ wh;

  always_comb begin
    pix_en   = 1'b0;
    pix_idx  = pos_r;
    pix_dark = 1'b0;
    case (cfg.depth_mode)
      DEPTH_GRAY: begin
        pix_en   = 1'b1;
        pix_idx  = pos_r;
        pix_dark = gray_dark;
      end
      DEPTH_RGB: begin
        pix_en   = (chan_r == CH_BLUE);
        pix_idx  = POS_W'(pix3_r);
        pix_dark = rgb_dark;
      end
      default: begin
        pix_en = 1'b0;
      end
    endcase
  end

  assign in_row   = pix_en && (pix_idx < w_ext);
  assign acc_set  = acc_r | ((in_row && pix_dark) ? (8'h80 >> pix_idx[2:0]) : 8'h00);
  assign pix_emit = in_row && ((pix_idx[2:0] == 3'd7) || (pix_idx + 14'd1 == w_ext));

  always_comb begin
    has_data  = 1'b0;
    data_byte = acc_set;
    acc_after = acc_r;
    case (cfg.depth_mode)
      DEPTH_ONE_BIT: begin
        has_data  = pos_r < bpr;
        data_byte = source_byte ^ pad_byte;
        acc_after = acc_r;
      end
      DEPTH_GRAY, DEPTH_RGB: begin
        has_data  = pix_emit;
        data_byte = acc_set;
        acc_after = pix_emit ? 8'h00 : acc_set;
      end
      default: begin
        has_data  = 1'b0;
        acc_after = acc_r;
      end
    endcase
  end

  assign pc_after  = pc_r + POS_W'(has_data);
  assign remaining = (pc_after < bpr) ? (bpr - pc_after) : '0;
  assign limit     = PAD_LIM - CNT_W'(has_data);
  assign trunc     = row_end && (remaining > POS_W'(limit));
  assign pad_n     = !row_end ? '0 : (trunc ? limit : CNT_W'(remaining));
  assign pad_first = acc_after | pad_byte;

  assign job.cnt       = CNT_W'(has_data) + pad_n;
  assign job.b0        = has_data ? data_byte : pad_first;
  assign job.b1        = has_data ? pad_first : pad_byte;
  assign job.b2        = pad_byte;
  assign job.fin_row   = (pad_n != '0) || (pc_after == bpr);
  assign job.fin_label = job.fin_row && label_end;
  assign job.trunc     = trunc;

  always_comb begin
    pos_nxt   = pos_r + 14'd1;
    pc_nxt    = pc_after;
    acc_nxt   = acc_after;
    red_nxt   = red_r;
    green_nxt = green_r;
    chan_nxt  = (chan_r == CH_BLUE) ? CH_RED : (chan_r + 2'd1);
    pix3_nxt  = pix3_r + PIX3_W'(chan_r == CH_BLUE);
    row_nxt   = row_r;
    if (cfg.depth_mode == DEPTH_RGB && chan_r == CH_RED) begin
      red_nxt = source_byte;
    end
    if (cfg.depth_mode == DEPTH_RGB && chan_r == CH_GREEN) begin
      green_nxt = source_byte;
    end
    if (row_end) begin
      pos_nxt   = '0;
      pc_nxt    = '0;
      acc_nxt   = '0;
      red_nxt   = '0;
      green_nxt = '0;
      chan_nxt  = CH_RED;
      pix3_nxt  = '0;
      row_nxt   = label_end ? '0 : (row_r + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      pc_r    <= '0;
      acc_r   <= '0;
      red_r   <= '0;
      green_r <= '0;
      chan_r  <= CH_RED;
      pix3_r  <= '0;
      row_r   <= '0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      chan_r  <= chan_nxt;
      pix3_r  <= pix3_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/r2m_emit.sv
`default_nettype none
module r2m_emit
  import r2m_pkg::*;
#(
  parameter int MAX_PAD_RESULTS = R2M_MAX_PAD
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire job_t             job,
  input  wire logic             take,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_mono_byte,
  output logic [HEX_W-1:0]      out_hex_high,
  output logic [HEX_W-1:0]      out_hex_low,
  output logic                  out_last_of_row,
  output logic                  out_last_of_label,
  output logic                  out_pad_truncated
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       b0_r, b1_r, b2_r;
  logic             fin_row_r, fin_label_r, trunc_r;
  logic             out_fire;
  logic             final_beat;

  assign out_valid  = (cnt_r != '0);
  assign out_fire   = out_valid && !out_stall;
  assign final_beat = (cnt_r == 7'd1);
  // A new beat may enter while the last result of the previous one leaves.
  assign can_load   = (cnt_r == '0) || (final_beat && !out_stall);

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = job.cnt;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b0_r        <= job.b0;
      b1_r        <= job.b1;
      b2_r        <= job.b2;
      fin_row_r   <= job.fin_row;
      fin_label_r <= job.fin_label;
      trunc_r     <= job.trunc;
    end else if (out_fire) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

  assign out_mono_byte     = b0_r;
  assign out_hex_high      = hex_digit(b0_r[7:4]);
  assign out_hex_low       = hex_digit(b0_r[3:0]);
  assign out_last_of_row   = final_beat && fin_row_r;
  assign out_last_of_label = final_beat && fin_label_r;
  assign out_pad_truncated = trunc_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PAD_RESULTS))
    else $error("result count exceeds the per-beat limit");

  a_label_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_last_of_label || out_last_of_row))
    else $error("label end without row end");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && cnt_r > 7'd1) |=> (cnt_r == $past(cnt_r) - 7'd1))
    else $error("new beat loaded while padding was still draining");

  a_trunc_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && cnt_r > 7'd1) |=> (out_pad_truncated == $past(out_pad_truncated)))
    else $error("truncation flag changed within one beat's results");

  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pad_truncated && final_beat) |-> out_last_of_row)
    else $error("truncated padding did not close the row");

endmodule
`default_nettype wire
